// File: rtl/core/cia_pkg.sv
package cia_pkg;

    localparam int ACTION_WIDTH = 4;
    localparam int STATUS_WIDTH = 3;
    localparam int PORT_WIDTH   = 64;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_ADD  = 4'd0,
        ACT_SUB  = 4'd1,
        ACT_MUL  = 4'd2,
        ACT_DIV  = 4'd3,
        ACT_REM  = 4'd4,
        ACT_AND  = 4'd5,
        ACT_OR   = 4'd6,
        ACT_XOR  = 4'd7,
        ACT_NEG  = 4'd8,
        ACT_NOT  = 4'd9,
        ACT_ABS  = 4'd10,
        ACT_EVEN = 4'd11,
        ACT_ODD  = 4'd12
    } action_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK      = 3'd0,
        ST_OVF     = 3'd1,
        ST_ZDIV    = 3'd2,
        ST_INEXACT = 3'd3,
        ST_UNSUP   = 3'd4
    } status_t;

endpackage

// File: rtl/core/checked_integer_alu.sv
// Throughput: one request per cycle; each stage advances whenever the stage
// after it is empty or advancing, so bubbles collapse under backpressure.
// The divider (one quotient bit per stage) sets the pipeline depth.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is not reset.
module checked_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [cia_pkg::ACTION_WIDTH-1:0]      s_action,
    input  logic signed [cia_pkg::PORT_WIDTH-1:0] s_operand_a,
    input  logic signed [cia_pkg::PORT_WIDTH-1:0] s_operand_b,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cia_pkg::PORT_WIDTH-1:0] m_result_value,
    output logic [cia_pkg::STATUS_WIDTH-1:0]      m_status
);

    localparam int W     = DATA_WIDTH;
    // Split of each magnitude for the partial products: low half LO_W, high HI_W.
    localparam int LO_W  = (W + 1) / 2;
    localparam int HI_W  = W - LO_W;
    // Stage 0 input, stage 1 magnitudes, stages 2..W+1 divide, stage W+2 result.
    localparam int LAST  = W + 2;
    localparam int DIV0  = 2;

    typedef struct packed {
        logic [cia_pkg::ACTION_WIDTH-1:0] action;
        logic [W-1:0]                     a;
        logic [W-1:0]                     b;
        logic [W-1:0]                     ua;
        logic [W-1:0]                     ub;
        logic                             b_zero;
        logic                             b_minus_one;
        logic                             a_min;
        logic [2*LO_W-1:0]                p00;
        logic [LO_W+HI_W-1:0]             p01;
        logic [LO_W+HI_W-1:0]             p10;
        logic [2*HI_W-1:0]                p11;
        logic                             mul_ovf;
        logic [W-1:0]                     mul_res;
        logic [W-1:0]                     rem;
        logic [W-1:0]                     quo;
    } stage_t;

    stage_t                      stg_reg  [0:LAST-1];
    stage_t                      stg_next [0:LAST-1];
    logic   [LAST:0]             vld_reg;
    logic   [LAST:0]             adv;
    logic signed [W-1:0]         result_reg;
    logic signed [W-1:0]         result_next;
    logic [cia_pkg::STATUS_WIDTH-1:0] status_reg;
    logic [cia_pkg::STATUS_WIDTH-1:0] status_next;

    // A stage advances when it is empty or its successor advances.
    assign adv[LAST] = !vld_reg[LAST] || m_ready;
    genvar gi;
    generate
        for (gi = 0; gi < LAST; gi++) begin : g_adv
            assign adv[gi] = !vld_reg[gi] || adv[gi+1];
        end
    endgenerate

    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: capture the request, keep the low DATA_WIDTH bits.
    always_comb begin
        stg_next[0]        = stg_reg[0];
        stg_next[0].action = s_action;
        stg_next[0].a      = s_operand_a[W-1:0];
        stg_next[0].b      = s_operand_b[W-1:0];
    end

    // Stage 1: magnitudes and operand flags; clear divider state.
    always_comb begin
        stg_next[1]             = stg_reg[0];
        stg_next[1].ua          = stg_reg[0].a[W-1] ? W'(0) - stg_reg[0].a : stg_reg[0].a;
        stg_next[1].ub          = stg_reg[0].b[W-1] ? W'(0) - stg_reg[0].b : stg_reg[0].b;
        stg_next[1].b_zero      = (stg_reg[0].b == '0);
        stg_next[1].b_minus_one = (stg_reg[0].b == '1);
        stg_next[1].a_min       = (stg_reg[0].a == {1'b1, {(W-1){1'b0}}});
        stg_next[1].rem         = '0;
        stg_next[1].quo         = '0;
    end

    // Stages 2..W+1: one restoring-divide step each. Stage 2 also forms the
    // partial products, stage 3 combines them, stage 4 checks overflow and
    // applies the sign.
    generate
        for (gi = DIV0; gi < LAST; gi++) begin : g_div
            logic [W:0]   trial;
            logic         take;
            logic [2*W-1:0] prod;
            logic [W-1:0]   limit;
            logic           neg;
            always_comb begin
                stg_next[gi] = stg_reg[gi-1];
                trial = {stg_reg[gi-1].rem, stg_reg[gi-1].ua[W-1-(gi-DIV0)]};
                take  = (trial >= {1'b0, stg_reg[gi-1].ub});
                stg_next[gi].rem = take ? W'(trial - {1'b0, stg_reg[gi-1].ub})
                                        : trial[W-1:0];
                stg_next[gi].quo = {stg_reg[gi-1].quo[W-2:0], take};
                prod  = '0;
                limit = '0;
                neg   = stg_reg[gi-1].a[W-1] ^ stg_reg[gi-1].b[W-1];
                if (gi == DIV0) begin
                    stg_next[gi].p00 = (2*LO_W)'(stg_reg[gi-1].ua[LO_W-1:0])
                                     * (2*LO_W)'(stg_reg[gi-1].ub[LO_W-1:0]);
                    stg_next[gi].p01 = (LO_W+HI_W)'(stg_reg[gi-1].ua[LO_W-1:0])
                                     * (LO_W+HI_W)'(stg_reg[gi-1].ub[W-1:LO_W]);
                    stg_next[gi].p10 = (LO_W+HI_W)'(stg_reg[gi-1].ua[W-1:LO_W])
                                     * (LO_W+HI_W)'(stg_reg[gi-1].ub[LO_W-1:0]);
                    stg_next[gi].p11 = (2*HI_W)'(stg_reg[gi-1].ua[W-1:LO_W])
                                     * (2*HI_W)'(stg_reg[gi-1].ub[W-1:LO_W]);
                end
                if (gi == DIV0 + 1) begin
                    prod = (2*W)'(stg_reg[gi-1].p00)
                         + ((2*W)'(stg_reg[gi-1].p01) << LO_W)
                         + ((2*W)'(stg_reg[gi-1].p10) << LO_W)
                         + ((2*W)'(stg_reg[gi-1].p11) << (2*LO_W));
                    stg_next[gi].mul_ovf = (prod[2*W-1:W] != '0);
                    stg_next[gi].mul_res = prod[W-1:0];
                end
                if (gi == DIV0 + 2) begin
                    limit = {1'b0, {(W-1){1'b1}}} + W'(neg);
                    stg_next[gi].mul_ovf = stg_reg[gi-1].mul_ovf
                                        || (stg_reg[gi-1].mul_res > limit);
                    stg_next[gi].mul_res = neg ? W'(0) - stg_reg[gi-1].mul_res
                                               : stg_reg[gi-1].mul_res;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        for (int k = 0; k < LAST; k++) begin
            if (adv[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (adv[LAST]) begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    // Final stage: pick the result and status by action.
    logic [W:0]   sum_ext;
    logic [W:0]   dif_ext;
    logic [W-1:0] q_signed;
    logic [W-1:0] r_signed;
    stage_t       fin;

    always_comb begin
        fin         = stg_reg[LAST-1];
        sum_ext     = {fin.a[W-1], fin.a} + {fin.b[W-1], fin.b};
        dif_ext     = {fin.a[W-1], fin.a} - {fin.b[W-1], fin.b};
        q_signed    = (fin.a[W-1] ^ fin.b[W-1]) ? W'(0) - fin.quo : fin.quo;
        r_signed    = fin.a[W-1] ? W'(0) - fin.rem : fin.rem;
        result_next = '0;
        status_next = cia_pkg::ST_OK;
        case (fin.action)
            cia_pkg::ACT_ADD: begin
                if (sum_ext[W] != sum_ext[W-1]) status_next = cia_pkg::ST_OVF;
                else result_next = sum_ext[W-1:0];
            end
            cia_pkg::ACT_SUB: begin
                if (dif_ext[W] != dif_ext[W-1]) status_next = cia_pkg::ST_OVF;
                else result_next = dif_ext[W-1:0];
            end
            cia_pkg::ACT_MUL: begin
                if (fin.mul_ovf) status_next = cia_pkg::ST_OVF;
                else result_next = fin.mul_res;
            end
            cia_pkg::ACT_DIV: begin
                if (fin.b_zero) status_next = cia_pkg::ST_ZDIV;
                else if (fin.b_minus_one && fin.a_min) status_next = cia_pkg::ST_OVF;
                else if (fin.rem != '0) status_next = cia_pkg::ST_INEXACT;
                else result_next = q_signed;
            end
            cia_pkg::ACT_REM: begin
                if (fin.b_zero) status_next = cia_pkg::ST_ZDIV;
                else if (!fin.b_minus_one) result_next = r_signed;
            end
            cia_pkg::ACT_AND: result_next = fin.a & fin.b;
            cia_pkg::ACT_OR:  result_next = fin.a | fin.b;
            cia_pkg::ACT_XOR: result_next = fin.a ^ fin.b;
            cia_pkg::ACT_NEG: begin
                if (fin.a_min) status_next = cia_pkg::ST_OVF;
                else result_next = W'(0) - fin.a;
            end
            cia_pkg::ACT_NOT: result_next = ~fin.a;
            cia_pkg::ACT_ABS: begin
                if (fin.a_min) status_next = cia_pkg::ST_OVF;
                else result_next = fin.ua;
            end
            cia_pkg::ACT_EVEN: result_next = W'(!fin.a[0]);
            cia_pkg::ACT_ODD:  result_next = W'(fin.a[0]);
            default: status_next = cia_pkg::ST_UNSUP;
        endcase
    end

    assign m_valid        = vld_reg[LAST];
    assign m_result_value = cia_pkg::PORT_WIDTH'(result_reg);
    assign m_status       = status_reg;

endmodule

// File: rtl/core/checked_integer_alu_checker.sv
module checked_integer_alu_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [cia_pkg::PORT_WIDTH-1:0] m_result_value,
    input logic [cia_pkg::STATUS_WIDTH-1:0]      m_status
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= cia_pkg::ST_UNSUP))
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != cia_pkg::ST_OK) |-> (m_result_value == '0))
        else $error("nonzero result with error status");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("stalled result dropped or changed");

endmodule

bind checked_integer_alu checked_integer_alu_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_status       (m_status)
);
